// ----- sv/sacl_pkg.sv -----
// Package for the set-associative cache tag and LRU store.
// Holds the field widths, register indexes, control structs and the saturating increment helper.
// It depends on nothing else.
`default_nettype none
package sacl_pkg;

  localparam int unsigned AGE_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned OFFSET_W   = 5;
  localparam int unsigned SETB_W     = 4;
  localparam int unsigned WAYB_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned OUT_WAY_W  = 3;
  localparam int unsigned OUT_SET_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAY    = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd6;
  localparam logic [SETB_W-1:0]   SETB_RST   = 4'd4;
  localparam logic [WAYB_W-1:0]   WAYB_RST   = 2'd0;

  typedef struct packed {
    logic clr;
    logic cap;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ----- sv/sacl_ctrl.sv -----
// Controller of the cache tag and LRU store: clearing pass, lookup sequence and output beat.
// Depends on sacl_pkg for the command and status structs.
`default_nettype none
module sacl_ctrl
  import sacl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.clr = (state_q == ST_CLEAR);
    cmd_o.cap = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.upd = (state_q == ST_LOOK) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_o.cap) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (cmd_o.upd) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sacl_dp.sv -----
// Datapath of the cache tag and LRU store: configuration, address split, set memory,
// way compare, LRU choice, counters and result registers. Depends on sacl_pkg.
`default_nettype none
module sacl_dp
  import sacl_pkg::*;
#(
  parameter int unsigned MAX_LINES  = 512,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [ADDR_WIDTH-1:0] address_i,
  output logic                       hit_o,
  output logic [OUT_WAY_W-1:0]       way_used_o,
  output logic [OUT_SET_W-1:0]       set_number_o,
  output logic [CNT_W-1:0]           access_total_o,
  output logic [CNT_W-1:0]           miss_total_o
);

  localparam int unsigned LINE_BITS = $clog2(MAX_LINES + 1) - 1;
  localparam int unsigned WAY_LIM   = $clog2(MAX_WAYS + 1) - 1;
  localparam int unsigned BANK_BITS = (WAY_LIM < LINE_BITS) ? WAY_LIM : LINE_BITS;
  localparam int unsigned NB        = 1 << BANK_BITS;
  localparam int unsigned ROWS      = 1 << (LINE_BITS - BANK_BITS);
  localparam int unsigned LW        = (LINE_BITS > 0) ? LINE_BITS : 1;
  localparam int unsigned RW        = (LINE_BITS > BANK_BITS) ? LINE_BITS - BANK_BITS : 1;
  localparam int unsigned BW        = (BANK_BITS > 0) ? BANK_BITS : 1;
  localparam int unsigned ENT_W     = ADDR_WIDTH + AGE_W;
  localparam int unsigned ROW_W     = NB * ENT_W;

  logic [OFFSET_W-1:0] offset_q;
  logic [SETB_W-1:0]   setb_q;
  logic [WAYB_W-1:0]   wayb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
      setb_q   <= SETB_RST;
      wayb_q   <= WAYB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OFFSET: offset_q <= cfg_wdata_i;
        CFG_SET:    setb_q   <= cfg_wdata_i[SETB_W-1:0];
        CFG_WAY:    wayb_q   <= cfg_wdata_i[WAYB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective way and set index widths (log2 of the counts), limited by the memory geometry.
  logic [4:0]            wb, sb;
  logic [LW-1:0]         set_mask, set_d, base_d;
  logic [ADDR_WIDTH-1:0] tag_d;
  logic [RW-1:0]         row_d;
  logic [BW-1:0]         bank_d;

  always_comb begin
    wb       = (5'(wayb_q) > 5'(BANK_BITS)) ? 5'(BANK_BITS) : 5'(wayb_q);
    sb       = (5'(setb_q) > 5'(LINE_BITS) - wb) ? 5'(LINE_BITS) - wb : 5'(setb_q);
    set_mask = (LW'(1) << sb) - LW'(1);
    set_d    = LW'(address_i >> offset_q) & set_mask;
    tag_d    = address_i >> (6'(offset_q) + 6'(sb));
    base_d   = set_d << wb;
    row_d    = RW'(base_d >> BANK_BITS);
    bank_d   = BW'(base_d) & BW'(NB - 1);
  end

  // Clearing pass over all rows after reset.
  logic [RW-1:0] clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
    end else if (cmd_i.clr) begin
      clr_row_q <= clr_row_q + RW'(1);
    end
  end

  assign sts_o.clr_last = (clr_row_q == RW'(ROWS - 1));

  logic [ADDR_WIDTH-1:0] tag_q;
  logic [LW-1:0]         set_q;
  logic [RW-1:0]         row_q;
  logic [BW-1:0]         bank_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      tag_q  <= tag_d;
      set_q  <= set_d;
      row_q  <= row_d;
      bank_q <= bank_d;
    end
  end

  // Set memory: one row holds the tag and age of every bank.
  logic [ROW_W-1:0] mem_q [ROWS];
  logic [ROW_W-1:0] rd_q;
  logic [ROW_W-1:0] row_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_row_q] <= '0;
    end else if (cmd_i.upd) begin
      mem_q[row_q] <= row_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      rd_q <= mem_q[row_d];
    end
  end

  logic [ADDR_WIDTH-1:0] way_tag [NB];
  logic [AGE_W-1:0]      way_age [NB];
  logic                  way_ok  [NB];
  logic [NB-1:0]         match;
  logic                  hit;
  logic [BW-1:0]         hit_way;
  logic [AGE_W-1:0]      t_age [BANK_BITS+1][NB];
  logic [BW-1:0]         t_idx [BANK_BITS+1][NB];
  logic                  t_ok  [BANK_BITS+1][NB];
  logic                  take_b;
  logic [BW-1:0]         pick, bank_sel;
  logic [CNT_W-1:0]      clock_new;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      logic [BW-1:0] k;
      k          = bank_q + BW'(i);
      way_tag[i] = rd_q[k*ENT_W+AGE_W +: ADDR_WIDTH];
      way_age[i] = rd_q[k*ENT_W +: AGE_W];
      way_ok[i]  = (i < (1 << wb));
      match[i]   = way_ok[i] && (way_age[i] != '0) && (way_tag[i] == tag_q);
    end
    hit     = |match;
    hit_way = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (match[i]) hit_way = BW'(i);
    end
  end

  // Registered-free reduction tree for the oldest way; empty ways carry age zero and
  // ties go to the lower way.
  always_comb begin
    take_b = 1'b0;
    for (int l = 0; l <= BANK_BITS; l++) begin
      for (int j = 0; j < NB; j++) begin
        t_age[l][j] = '0;
        t_idx[l][j] = '0;
        t_ok[l][j]  = 1'b0;
      end
    end
    for (int j = 0; j < NB; j++) begin
      t_age[0][j] = way_age[j];
      t_idx[0][j] = BW'(j);
      t_ok[0][j]  = way_ok[j];
    end
    for (int l = 0; l < BANK_BITS; l++) begin
      for (int j = 0; j < (NB >> (l + 1)); j++) begin
        take_b = t_ok[l][2*j+1] &&
                 (!t_ok[l][2*j] || (t_age[l][2*j+1] < t_age[l][2*j]));
        t_age[l+1][j] = take_b ? t_age[l][2*j+1] : t_age[l][2*j];
        t_idx[l+1][j] = take_b ? t_idx[l][2*j+1] : t_idx[l][2*j];
        t_ok[l+1][j]  = t_ok[l][2*j+1] || t_ok[l][2*j];
      end
    end
  end

  logic [CNT_W-1:0] age_clk_q, access_q, miss_q;

  always_comb begin
    pick      = hit ? hit_way : t_idx[BANK_BITS][0];
    bank_sel  = bank_q + pick;
    clock_new = sat_inc(age_clk_q);
    row_new   = rd_q;
    if (hit) begin
      row_new[bank_sel*ENT_W +: AGE_W] = clock_new;
    end else begin
      row_new[bank_sel*ENT_W +: ENT_W] = {tag_q, clock_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_clk_q <= '0;
      access_q  <= '0;
      miss_q    <= '0;
    end else if (cmd_i.upd) begin
      age_clk_q <= clock_new;
      access_q  <= sat_inc(access_q);
      if (!hit) miss_q <= sat_inc(miss_q);
    end
  end

  logic [BW+OUT_WAY_W-1:0] way_ext;
  logic [LW+OUT_SET_W-1:0] set_ext;

  assign way_ext = {{OUT_WAY_W{1'b0}}, pick};
  assign set_ext = {{OUT_SET_W{1'b0}}, set_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      hit_o          <= hit;
      way_used_o     <= way_ext[OUT_WAY_W-1:0];
      set_number_o   <= set_ext[OUT_SET_W-1:0];
      access_total_o <= sat_inc(access_q);
      miss_total_o   <= hit ? miss_q : sat_inc(miss_q);
    end
  end

endmodule
`default_nettype wire

// ----- sv/set_assoc_cache_lru_tags.sv -----
// Top level of the set-associative cache tag and LRU store.
// Instantiates sacl_ctrl and sacl_dp; depends on sacl_pkg.
//
// Each accepted address beat is looked up in its set and answered with one result beat
// giving hit or miss, the way used, the set, and saturating access and miss totals.
// An access has two steps: the accept cycle reads the whole set row from the set
// memory into a register, and the lookup state compares the configured ways, picks the
// hit way or else the least recently used way and writes the row back, then returns to
// idle, so no new address is taken before the last one is written back. A result that
// is not yet taken holds back only the write-back of the following access. After reset
// a clearing pass writes one row per cycle over all 2**(log2(MAX_LINES) - log2(ways
// per row)) rows (64 with the default parameters) before the first address is accepted;
// configuration writes are taken at any time but are meant for an idle block.
`default_nettype none
module set_assoc_cache_lru_tags
  import sacl_pkg::*;
#(
  parameter int unsigned MAX_LINES  = 512,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ADDR_WIDTH-1:0] address_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       hit_o,
  output logic [OUT_WAY_W-1:0]       way_used_o,
  output logic [OUT_SET_W-1:0]       set_number_o,
  output logic [CNT_W-1:0]           access_total_o,
  output logic [CNT_W-1:0]           miss_total_o
);

  cmd_t cmd;
  sts_t sts;

  sacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sacl_dp #(
    .MAX_LINES  (MAX_LINES),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .address_i      (address_i),
    .hit_o          (hit_o),
    .way_used_o     (way_used_o),
    .set_number_o   (set_number_o),
    .access_total_o (access_total_o),
    .miss_total_o   (miss_total_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("address accepted while a lookup is still in progress");

  a_upd_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd |=> (out_valid_o && (access_total_o != '0)))
    else $error("write-back did not present a result beat");

  a_miss_le_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (miss_total_o <= access_total_o))
    else $error("miss total exceeds access total");

  a_no_clear_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> (!cmd.cap && !cmd.upd && !out_valid_o))
    else $error("clearing pass overlaps a lookup");

endmodule
`default_nettype wire
